/* rtl/core/iol_pkg.sv */
package iol_pkg;

    // Operation codes carried by each input transfer
    typedef enum logic [2:0] {
        FN_INSERT      = 3'd0,
        FN_APPEND      = 3'd1,
        FN_REMOVE      = 3'd2,
        FN_REMOVE_LAST = 3'd3,
        FN_REPLACE     = 3'd4,
        FN_SELECT      = 3'd5,
        FN_SEARCH      = 3'd6,
        FN_UNUSED      = 3'd7
    } t_func;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_WRITE      = 2'd1,
        CELL_SHIFT_UP   = 2'd2,
        CELL_SHIFT_DOWN = 2'd3
    } t_cell_op;

endpackage

/* rtl/core/iol_ifs.sv */
interface iol_op_if
    import iol_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 5
) ();
    logic                         valid;
    logic                         ready;
    t_func                        func;
    logic [POS_W-1:0]             position_in;
    logic signed [DATA_WIDTH-1:0] item_value;

    modport source (output valid, func, position_in, item_value, input ready);
    modport sink   (input valid, func, position_in, item_value, output ready);
endinterface

interface iol_res_if #(
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 5
) ();
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic signed [DATA_WIDTH-1:0] read_value;
    logic [POS_W-1:0]             found_at;
    logic [POS_W-1:0]             count;
    logic                         is_empty;
    logic                         is_full;

    modport source (output valid, ok, read_value, found_at, count, is_empty, is_full,
                    input ready);
    modport sink   (input valid, ok, read_value, found_at, count, is_empty, is_full,
                    output ready);
endinterface

/* rtl/core/iol_cell.sv */
module iol_cell
    import iol_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int POS_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [POS_W-1:0]      i_pos,
    input  logic [POS_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic                  i_found_left,
    output logic                  o_found,
    output logic                  o_hit,
    output logic [DATA_WIDTH-1:0] o_value
);

    localparam logic [POS_W-1:0] IDX = INDEX[POS_W-1:0];

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  match;

    always_comb begin
        n_value = r_value;
        unique case (i_op)
            CELL_HOLD: begin
                n_value = r_value;
            end
            CELL_WRITE: begin
                if (IDX == i_pos) n_value = i_wdata;
            end
            CELL_SHIFT_UP: begin
                if (IDX == i_pos)     n_value = i_wdata;
                else if (IDX > i_pos) n_value = i_left;
            end
            CELL_SHIFT_DOWN: begin
                if (IDX >= i_pos) n_value = i_right;
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Only live entries take part in the search; the first match wins
    assign match   = (r_value == i_wdata) && (IDX < i_count);
    assign o_hit   = match && !i_found_left;
    assign o_found = i_found_left || match;
    assign o_value = r_value;

endmodule

/* rtl/core/indexed_ordered_list.sv */
// Each accepted input transfer loads its result into the output register.
// Throughput: one operation per cycle; a new transfer is taken while the result
//   register is empty or being drained in the same cycle.
// The cycle time is set by the search: a first-match chain through every cell.
// Reset (synchronous, active low) clears the entry count and the result valid;
//   stored entries are not cleared and hold whatever was last written.
module indexed_ordered_list
    import iol_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iol_op_if.sink     i_op,
    iol_res_if.source  o_res
);

    // Count must hold DEPTH itself, so positions share that width
    localparam int              CNT_W   = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Chain wiring: value, left/right neighbor and first-match carry
    logic [DATA_WIDTH-1:0] cell_value [DEPTH];
    logic [DATA_WIDTH-1:0] cell_left  [DEPTH];
    logic [DATA_WIDTH-1:0] cell_right [DEPTH];
    logic                  found_in   [DEPTH];
    logic                  found_out  [DEPTH];
    logic                  hit        [DEPTH];

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic                  r_out_valid;
    logic                  r_ok;
    logic [DATA_WIDTH-1:0] r_read_value;
    logic [CNT_W-1:0]      r_found_at;
    logic [CNT_W-1:0]      r_out_count;
    logic                  r_is_empty;
    logic                  r_is_full;

    logic                  accept;
    logic                  n_ok;
    logic [DATA_WIDTH-1:0] n_read_value;
    logic [CNT_W-1:0]      n_found_at;
    t_cell_op              cell_op;
    logic [CNT_W-1:0]      cell_pos;
    logic [CNT_W-1:0]      sel_idx;
    logic [DATA_WIDTH-1:0] sel_value;
    logic [CNT_W-1:0]      hit_idx;
    logic [DATA_WIDTH-1:0] wdata;

    // Take a transfer whenever the result register is free or drains now;
    // refuse everything while reset is held
    assign i_op.ready = i_rst_n && (!r_out_valid || o_res.ready);
    assign accept     = i_op.valid && i_op.ready;
    assign wdata      = i_op.item_value;

    // Build the row of cells; each end ties off to something harmless
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign cell_left[g] = wdata;
            assign found_in[g]  = 1'b0;
        end else begin : g_inner
            assign cell_left[g] = cell_value[g-1];
            assign found_in[g]  = found_out[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign cell_right[g] = cell_value[g];
        end else begin : g_mid
            assign cell_right[g] = cell_value[g+1];
        end

        iol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .POS_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (cell_op),
            .i_pos        (cell_pos),
            .i_count      (r_count),
            .i_wdata      (wdata),
            .i_left       (cell_left[g]),
            .i_right      (cell_right[g]),
            .i_found_left (found_in[g]),
            .o_found      (found_out[g]),
            .o_hit        (hit[g]),
            .o_value      (cell_value[g])
        );
    end

    // Select clamps to the last entry; gather the chosen cell and the hit index
    assign sel_idx = (i_op.position_in < r_count) ? i_op.position_in : r_count - 1'b1;

    always_comb begin
        sel_value = '0;
        hit_idx   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == sel_idx) sel_value = sel_value | cell_value[i];
            if (hit[i])               hit_idx   = hit_idx | CNT_W'(i);
        end
    end

    // Decode the operation into a cell command, the new count and the result
    always_comb begin
        cell_op      = CELL_HOLD;
        cell_pos     = i_op.position_in;
        n_count      = r_count;
        n_ok         = 1'b0;
        n_read_value = '0;
        n_found_at   = '0;
        unique case (i_op.func)
            FN_INSERT: begin
                if ((r_count != DEPTH_C) && (i_op.position_in <= r_count)) begin
                    n_ok    = 1'b1;
                    cell_op = CELL_SHIFT_UP;
                    n_count = r_count + 1'b1;
                end
            end
            FN_APPEND: begin
                cell_pos = r_count;
                if (r_count != DEPTH_C) begin
                    n_ok    = 1'b1;
                    cell_op = CELL_WRITE;
                    n_count = r_count + 1'b1;
                end
            end
            FN_REMOVE: begin
                if (i_op.position_in < r_count) begin
                    n_ok    = 1'b1;
                    cell_op = CELL_SHIFT_DOWN;
                    n_count = r_count - 1'b1;
                end
            end
            FN_REMOVE_LAST: begin
                // Dropping the tail needs no data movement
                if (r_count != '0) begin
                    n_ok    = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            FN_REPLACE: begin
                if (i_op.position_in < r_count) begin
                    n_ok    = 1'b1;
                    cell_op = CELL_WRITE;
                end
            end
            FN_SELECT: begin
                n_ok = 1'b1;
                if (r_count != '0) n_read_value = sel_value;
            end
            FN_SEARCH: begin
                n_ok       = 1'b1;
                n_found_at = found_out[DEPTH-1] ? hit_idx : r_count;
            end
            FN_UNUSED: begin
                n_ok = 1'b0;
            end
            default: n_ok = 1'b0;
        endcase
        // Hold the cells unless this cycle carries a transfer
        if (!accept) begin
            cell_op = CELL_HOLD;
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on transfer, hold while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok         <= n_ok;
            r_read_value <= n_read_value;
            r_found_at   <= n_found_at;
            r_out_count  <= n_count;
            r_is_empty   <= (n_count == '0);
            r_is_full    <= (n_count == DEPTH_C);
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.ok         = r_ok;
    assign o_res.read_value = r_read_value;
    assign o_res.found_at   = r_found_at;
    assign o_res.count      = r_out_count;
    assign o_res.is_empty   = r_is_empty;
    assign o_res.is_full    = r_is_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count exceeds depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_op.func == FN_APPEND) && (r_count != DEPTH_C))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("append did not advance the count");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_res.count == r_count))
        else $error("reported count differs from stored count");

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.found_at <= o_res.count))
        else $error("search index past the end of the list");

endmodule
